### rtl/core/frpt_pkg.sv
// Package for the filtered peak-return trigger core.
// Holds widths, register reset values, register indexes, mode codes and payload structs.
// No dependencies; used by frpt_div and filtered_peak_return_trigger_core.
`default_nettype none

package frpt_pkg;

  // Field and datapath widths
  localparam int TICK_BITS    = 24;
  localparam int FRAC_BITS    = 16;
  localparam int SAMPLE_BITS  = 10;
  localparam int FILT_BITS    = SAMPLE_BITS + FRAC_BITS;
  localparam int RC_BITS      = 32;
  localparam int DEN_BITS     = RC_BITS + 1;
  localparam int PROD_BITS    = FRAC_BITS + FILT_BITS;
  localparam int CNT_BITS     = $clog2(FRAC_BITS);
  localparam int CFG_IDX_BITS = 2;

  // Register reset values
  localparam logic [RC_BITS-1:0]     RC_RESET   = 32'd2546479;
  localparam logic [SAMPLE_BITS-1:0] PEAK_RESET = 10'd100;
  localparam logic [SAMPLE_BITS-1:0] DROP_RESET = 10'd70;
  localparam logic [SAMPLE_BITS-1:0] LOW_RESET  = 10'd10;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RC        = 2'd0,
    CFG_INIT_PEAK = 2'd1,
    CFG_DROP      = 2'd2,
    CFG_LOW       = 2'd3
  } cfg_idx_t;

  // Trigger mode, as reported on the phase field
  typedef enum logic [1:0] {
    MODE_TRACK = 2'd0,
    MODE_ARMED = 2'd1,
    MODE_DONE  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [TICK_BITS-1:0]   elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    logic                   fire;
    logic [1:0]             phase;
    logic [SAMPLE_BITS-1:0] level;
    logic [SAMPLE_BITS-1:0] peak;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/frpt_div.sv
// Restoring divider for the filter gain: quot = (ticks << FRAC_BITS) / (rc + ticks).
// One quotient bit per cycle; rc of zero is taken as one.
// Depends on frpt_pkg.
`default_nettype none

module frpt_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [frpt_pkg::TICK_BITS-1:0] ticks,
  input  wire logic [frpt_pkg::RC_BITS-1:0]   rc,
  output logic                               done,
  output logic [frpt_pkg::FRAC_BITS-1:0]     quot
);

  localparam logic [frpt_pkg::CNT_BITS-1:0] LAST_STEP =
    frpt_pkg::CNT_BITS'(frpt_pkg::FRAC_BITS - 1);

  logic                              busy_r;
  logic                              done_r;
  logic [frpt_pkg::CNT_BITS-1:0]     cnt_r;
  logic [frpt_pkg::DEN_BITS-1:0]     den_r;
  logic [frpt_pkg::DEN_BITS-1:0]     rem_r;
  logic [frpt_pkg::FRAC_BITS-1:0]    quot_r;
  logic [frpt_pkg::RC_BITS-1:0]      rc_eff;
  logic [frpt_pkg::DEN_BITS:0]       trial;
  logic [frpt_pkg::DEN_BITS:0]       trial_sub;
  logic                              fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    rc_eff    = (rc == '0) ? frpt_pkg::RC_BITS'(1) : rc;
    trial     = {rem_r, 1'b0};
    fits      = (trial >= {1'b0, den_r});
    trial_sub = trial - {1'b0, den_r};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient; remainder stays below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= frpt_pkg::DEN_BITS'(ticks);
      den_r <= frpt_pkg::DEN_BITS'(rc_eff) + frpt_pkg::DEN_BITS'(ticks);
    end else if (busy_r) begin
      rem_r  <= fits ? trial_sub[frpt_pkg::DEN_BITS-1:0] : trial[frpt_pkg::DEN_BITS-1:0];
      quot_r <= {quot_r[frpt_pkg::FRAC_BITS-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

### rtl/core/filtered_peak_return_trigger_core.sv
// Top level of the filtered peak-return trigger: sequencer, gain multiply, filter
// update, peak/arm/fire logic, configuration registers and output register.
// Depends on frpt_pkg and frpt_div.
//
//   channel | ports                        | direction | payload
//   --------+------------------------------+-----------+---------------------------
//   in      | in_valid, in_ready, in_item  | input     | sample, elapsed_ticks
//   out     | out_valid, out_ready, out_item| output   | fire, phase, level, peak
//   cfg     | cfg_valid, cfg_ready         | input     | cfg_index, cfg_data
//
// A transaction runs through the divide, multiply, update, check and final steps
// to the result register; the serial gain divider (one quotient bit per cycle) sets the pace.
// A transaction in done mode skips the arithmetic and goes from idle straight
// to the final step.
// Synchronous active-low reset clears filter, peak (to 100), mode and registers.
// in_ready is high only when the sequencer is idle; a result held by out_ready
// low stalls the sequencer in its final step. cfg_ready is always high.
`default_nettype none

module filtered_peak_return_trigger_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire frpt_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output frpt_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [frpt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [frpt_pkg::RC_BITS-1:0]      cfg_data
);

  localparam int FB = frpt_pkg::FRAC_BITS;
  localparam int FW = frpt_pkg::FILT_BITS;
  localparam int SB = frpt_pkg::SAMPLE_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MUL  = 6'b000100,
    S_UPD  = 6'b001000,
    S_CHK  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [frpt_pkg::RC_BITS-1:0]    rc_r;
  logic [SB-1:0]                   drop_r;
  logic [SB-1:0]                   low_r;
  logic [FW-1:0]                   filt_r;
  logic [SB-1:0]                   peak_r;
  frpt_pkg::mode_t                 mode_r;
  logic                            fire_r;
  logic [FW-1:0]                   diff_r;
  logic                            up_r;
  logic [frpt_pkg::PROD_BITS-1:0]  prod_r;
  logic                            out_valid_r;
  frpt_pkg::out_item_t             out_item_r;

  logic                            in_fire;
  logic                            div_done;
  logic [FB-1:0]                   alpha;
  logic [FW-1:0]                   s_fix;
  logic [FW-1:0]                   step;
  logic [SB-1:0]                   pk_new;
  logic [FW-1:0]                   peak_fix;
  logic [FW:0]                     arm_ref;
  logic                            arm;
  logic                            ret;
  logic                            out_load;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Configuration registers; initial_peak only matters at reset, so writes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r   <= frpt_pkg::RC_RESET;
      drop_r <= frpt_pkg::DROP_RESET;
      low_r  <= frpt_pkg::LOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        frpt_pkg::CFG_RC:        rc_r   <= cfg_data;
        frpt_pkg::CFG_DROP:      drop_r <= cfg_data[SB-1:0];
        frpt_pkg::CFG_LOW:       low_r  <= cfg_data[SB-1:0];
        frpt_pkg::CFG_INIT_PEAK: ;
        default: ;
      endcase
    end
  end

  // Gain divider
  frpt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire && (mode_r == frpt_pkg::MODE_TRACK || mode_r == frpt_pkg::MODE_ARMED)),
    .ticks (in_item.elapsed_ticks),
    .rc    (rc_r),
    .done  (div_done),
    .quot  (alpha)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (mode_r == frpt_pkg::MODE_TRACK || mode_r == frpt_pkg::MODE_ARMED) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DIV:   if (div_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_CHK;
      S_CHK:   state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Filter difference, taken at acceptance
  assign s_fix = {in_item.sample, FB'(0)};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      up_r   <= (s_fix >= filt_r);
      diff_r <= (s_fix >= filt_r) ? (s_fix - filt_r) : (filt_r - s_fix);
    end
  end

  // Gain times difference
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= frpt_pkg::PROD_BITS'(alpha) * frpt_pkg::PROD_BITS'(diff_r);
    end
  end

  assign step = prod_r[FB +: FW];

  // Peak, arm and return tests on the updated filter
  always_comb begin
    pk_new   = (filt_r[FW-1:FB] > peak_r) ? filt_r[FW-1:FB] : peak_r;
    arm_ref  = {1'b0, filt_r} + {1'b0, drop_r, FB'(0)};
    arm      = ({1'b0, pk_new, FB'(0)} > arm_ref) && (filt_r < {low_r, FB'(0)});
    peak_fix = {peak_r, FB'(0)};
    ret      = (filt_r >= peak_fix);
  end

  // Filter, peak and mode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
      peak_r <= frpt_pkg::PEAK_RESET;
      mode_r <= frpt_pkg::MODE_TRACK;
      fire_r <= 1'b0;
    end else begin
      if (in_fire) begin
        fire_r <= 1'b0;
      end
      if (state_r == S_UPD) begin
        filt_r <= up_r ? (filt_r + step) : (filt_r - step);
      end
      if (state_r == S_CHK) begin
        case (mode_r)
          frpt_pkg::MODE_TRACK: begin
            peak_r <= pk_new;
            if (arm) mode_r <= frpt_pkg::MODE_ARMED;
          end
          frpt_pkg::MODE_ARMED: begin
            if (ret) begin
              fire_r <= 1'b1;
              mode_r <= frpt_pkg::MODE_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.fire  <= fire_r;
      out_item_r.phase <= mode_r;
      out_item_r.level <= filt_r[FW-1:FB];
      out_item_r.peak  <= peak_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_fire_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.fire |-> out_item.phase == frpt_pkg::MODE_DONE)
    else $error("fire reported outside done mode");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == frpt_pkg::MODE_DONE |=> mode_r == frpt_pkg::MODE_DONE)
    else $error("left done mode");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide step");

  a_peak_armed: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != frpt_pkg::MODE_TRACK |=> $stable(peak_r))
    else $error("peak changed after arming");

endmodule

`default_nettype wire

### tb/filtered_peak_return_trigger_core_tb.sv
`timescale 1ns / 100ps
// Testbench for filtered_peak_return_trigger_core: directed and random sample
// transactions are checked against a behavioral filter/peak/arm predictor.
// Depends on frpt_pkg and the core RTL only.

module filtered_peak_return_trigger_core_tb;
  import frpt_pkg::*;

  localparam logic [TICK_BITS-1:0] TICKS_MAX = '1;
  localparam logic [RC_BITS-1:0]   RC_MAX    = '1;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  in_item_t                in_item   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_item_t               out_item;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [RC_BITS-1:0]      cfg_data  = '0;

  // Predictor copy of the registers and trigger state
  logic [RC_BITS-1:0]     rc_ticks_q  = RC_RESET;
  logic [SAMPLE_BITS-1:0] init_peak_q = PEAK_RESET;  // only matters at reset
  logic [SAMPLE_BITS-1:0] drop_q      = DROP_RESET;
  logic [SAMPLE_BITS-1:0] low_q       = LOW_RESET;
  logic [FILT_BITS-1:0]   filt_q      = '0;
  logic [SAMPLE_BITS-1:0] peak_q      = PEAK_RESET;
  mode_t                  mode_q      = MODE_TRACK;

  in_item_t    queued_samples[$];
  out_item_t   predicted_reports[$];
  out_item_t   expected_report;
  int unsigned samples_queued  = 0;
  int unsigned reports_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;

  filtered_peak_return_trigger_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Filter update, peak tracking and arm/fire decision for one sample
  function automatic out_item_t advance_trigger(in_item_t it);
    logic [63:0] rc, tk, gain, s, f, pk;
    out_item_t   rep;
    rep.fire = 1'b0;
    if (mode_q == MODE_TRACK || mode_q == MODE_ARMED) begin
      rc   = (rc_ticks_q == '0) ? 64'd1 : 64'(rc_ticks_q);
      tk   = 64'(it.elapsed_ticks);
      gain = (tk << FRAC_BITS) / (rc + tk);
      s    = 64'(it.sample) << FRAC_BITS;
      f    = 64'(filt_q);
      // step truncates toward zero, so the filter never overshoots the sample
      if (s >= f) f = f + ((gain * (s - f)) >> FRAC_BITS);
      else        f = f - ((gain * (f - s)) >> FRAC_BITS);
      filt_q = f[FILT_BITS-1:0];
      f      = 64'(filt_q);
      if (mode_q == MODE_TRACK) begin
        if (filt_q[FILT_BITS-1:FRAC_BITS] > peak_q) peak_q = filt_q[FILT_BITS-1:FRAC_BITS];
        pk = 64'(peak_q) << FRAC_BITS;
        if (pk > f && (pk - f) > (64'(drop_q) << FRAC_BITS) &&
            f < (64'(low_q) << FRAC_BITS))
          mode_q = MODE_ARMED;
      end else if (f >= (64'(peak_q) << FRAC_BITS)) begin
        rep.fire = 1'b1;
        mode_q   = MODE_DONE;
      end
    end
    rep.phase = mode_q;
    rep.level = filt_q[FILT_BITS-1:FRAC_BITS];
    rep.peak  = peak_q;
    return rep;
  endfunction

  // Sample driver: predicts on each accepted transaction, then loads the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_reports.push_back(advance_trigger(in_item));
      if (!in_valid || in_ready) begin
        if (queued_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item  <= queued_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor: compares each accepted report with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected report: fire=%0b phase=%0d level=%0d peak=%0d",
                     out_item.fire, out_item.phase, out_item.level, out_item.peak);
        end else begin
          expected_report = predicted_reports.pop_front();
          reports_checked++;
          if (out_item.fire !== expected_report.fire ||
              out_item.phase !== expected_report.phase ||
              out_item.level !== expected_report.level ||
              out_item.peak !== expected_report.peak) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"report %0d mismatch: expected fire=%0b phase=%0d level=%0d ",
                        "peak=%0d, got fire=%0b phase=%0d level=%0d peak=%0d"},
                       reports_checked, expected_report.fire, expected_report.phase,
                       expected_report.level, expected_report.peak, out_item.fire,
                       out_item.phase, out_item.level, out_item.peak);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Register write; predictor copy is updated when the transaction completes
  task automatic write_reg(cfg_idx_t idx, logic [RC_BITS-1:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RC:        rc_ticks_q  = data;
      CFG_INIT_PEAK: init_peak_q = data[SAMPLE_BITS-1:0];
      CFG_DROP:      drop_q      = data[SAMPLE_BITS-1:0];
      CFG_LOW:       low_q       = data[SAMPLE_BITS-1:0];
      default: ;
    endcase
  endtask

  // Hold off until every queued sample has been answered
  task automatic drain();
    @(posedge clk);
    while (reports_checked != samples_queued) @(posedge clk);
  endtask

  task automatic queue_sample(int unsigned level, logic [TICK_BITS-1:0] ticks);
    in_item_t it;
    it.sample        = level[SAMPLE_BITS-1:0];
    it.elapsed_ticks = ticks;
    queued_samples.push_back(it);
    samples_queued++;
  endtask

  // Mix of zero, tiny, mid-range and saturated tick counts
  function automatic logic [TICK_BITS-1:0] rand_ticks();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TICKS_MAX;
      2, 3:    return TICK_BITS'($urandom_range(1, 255));
      4, 5:    return TICK_BITS'($urandom_range(256, 65535));
      default: return TICK_BITS'($urandom);
    endcase
  endfunction

  // Plateaus and steps, including rail-to-rail swings
  task automatic queue_level_runs(int unsigned n);
    int unsigned level;
    level = $urandom_range(0, 1023);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       level = 0;
        1:       level = 1023;
        2, 3:    level = $urandom_range(0, 1023);
        default: ;
      endcase
      queue_sample(level, rand_ticks());
    end
  endtask

  // Samples kept under the held peak, so the armed block does not fire
  task automatic queue_below_peak(int unsigned n);
    int unsigned ceiling, level;
    ceiling = peak_q - 1;
    level   = 0;
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       level = 0;
        1:       level = ceiling;
        2, 3:    level = $urandom_range(0, ceiling);
        default: ;
      endcase
      queue_sample(level, rand_ticks());
    end
  endtask

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 53;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // low level of zero keeps the trigger tracking; peak load only applies at reset
    write_reg(CFG_LOW, 0);
    write_reg(CFG_INIT_PEAK, 1023);

    // default time constant: zero ticks hold the filter, then rail swings
    queue_sample(0, 0);
    queue_sample(1023, 0);
    queue_sample(1023, TICKS_MAX);
    queue_sample(1023, TICKS_MAX);
    queue_sample(0, 1);
    queue_sample(1023, 1);
    queue_sample(512, 24'd2546479);
    queue_sample(0, TICKS_MAX);
    drain();

    // shortest time constant: gain just under one
    write_reg(CFG_RC, 1);
    write_reg(CFG_DROP, 0);
    queue_sample(1023, TICKS_MAX);
    queue_sample(0, TICKS_MAX);
    queue_sample(1023, 1);
    queue_sample(0, 0);
    drain();

    // zero time constant behaves as one
    write_reg(CFG_RC, 0);
    queue_sample(1023, 1);
    queue_sample(0, TICKS_MAX);
    queue_sample(1023, TICKS_MAX);
    drain();

    // longest time constant: gain near zero
    write_reg(CFG_RC, RC_MAX);
    queue_sample(0, TICKS_MAX);
    queue_sample(1023, 1);
    drain();

    // random tracking, arming blocked by low level or by full drop margin
    write_reg(CFG_RC, $urandom_range(1, 4096));
    write_reg(CFG_DROP, $urandom_range(0, 1023));
    queue_level_runs(200);
    drain();

    write_reg(CFG_RC, 0);
    write_reg(CFG_DROP, 1023);
    write_reg(CFG_LOW, $urandom_range(0, 1023));
    queue_level_runs(200);
    drain();

    send_idle_pct = 53;
    recv_idle_pct = 32;
    write_reg(CFG_RC, $urandom >> $urandom_range(0, 31));
    write_reg(CFG_LOW, 1023);
    queue_level_runs(200);
    drain();

    write_reg(CFG_RC, 32'd1 << $urandom_range(8, 24));
    write_reg(CFG_LOW, 0);
    write_reg(CFG_DROP, $urandom_range(0, 1023));
    queue_level_runs(250);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_RC, RC_MAX);
    write_reg(CFG_DROP, 1023);
    write_reg(CFG_LOW, $urandom_range(0, 1023));
    queue_level_runs(100);
    drain();

    write_reg(CFG_RC, $urandom_range(1, 100000));
    write_reg(CFG_DROP, 0);
    write_reg(CFG_LOW, 0);
    write_reg(CFG_INIT_PEAK, 0);
    queue_level_runs(200);
    drain();

    // arm: zero margin, top low level; stay armed under the peak
    write_reg(CFG_RC, $urandom_range(16, 2048));
    write_reg(CFG_LOW, 1023);
    queue_below_peak(500);
    drain();

    // full-scale step returns to the peak and fires; later samples are ignored
    write_reg(CFG_RC, 1);
    queue_sample(1023, TICKS_MAX);
    queue_sample(0, TICKS_MAX);
    queue_sample(1023, 0);
    queue_sample(300, 24'd12345);
    drain();

    repeat (40) @(posedge clk);
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
